[hdl/loeq_pkg.sv]
// Shared types and constants of the lineage-ordered event queue.
package loeq_pkg;

  // Command codes carried by an input transfer.
  localparam logic [2:0] CMD_STAGE    = 3'd0;
  localparam logic [2:0] CMD_INSERT   = 3'd1;
  localparam logic [2:0] CMD_POP      = 3'd2;
  localparam logic [2:0] CMD_PEEK     = 3'd3;
  localparam logic [2:0] CMD_REMOVE   = 3'd4;
  localparam logic [2:0] CMD_CONTAINS = 3'd5;

  // Status codes carried by a result transfer.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // Slot word layout: {time, id, origin} in the low bits, then one
  // {anc_time, anc_system, anc_sequence, anc_origin} record per level.
  localparam int REC_W = 128;
  localparam int LVL_W = 160;

  // Outcome of one step of the ordering compare.
  typedef struct packed {
    logic done;
    logic lt;
  } cmp_res_t;

endpackage

[hdl/loeq_ram.sv]
// Generic single-port-write, registered-read RAM.
module loeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/loeq_cmp.sv]
// One step of the event ordering compare: timestamp, or one lineage level.
module loeq_cmp #(
  parameter int LINEAGE_DEPTH = 4
) (
  input  logic [loeq_pkg::REC_W+LINEAGE_DEPTH*loeq_pkg::LVL_W-1:0] cand,
  input  logic [loeq_pkg::REC_W+LINEAGE_DEPTH*loeq_pkg::LVL_W-1:0] best,
  input  logic [$clog2(LINEAGE_DEPTH+1)-1:0]                       step,
  output loeq_pkg::cmp_res_t                                       res
);

  localparam int W  = loeq_pkg::REC_W + LINEAGE_DEPTH * loeq_pkg::LVL_W;
  localparam int PW = $clog2(W);
  localparam int SW = $clog2(LINEAGE_DEPTH + 1);

  logic [PW-1:0] lb;
  logic [PW-1:0] cb;
  logic          id_lt;
  logic          last_lvl;

  always_comb begin
    // Level step-1 starts at lb; its child origin sits at cb.
    lb = PW'(loeq_pkg::REC_W) + PW'(step - SW'(1)) * PW'(loeq_pkg::LVL_W);
    cb = (step == SW'(1)) ? PW'(0) : PW'(lb - PW'(loeq_pkg::LVL_W));
    id_lt = cand[63:32] < best[63:32];
    last_lvl = (step == SW'(LINEAGE_DEPTH));
    res = '{done: 1'b0, lt: 1'b0};
    if (step == SW'(0)) begin
      if (cand[127:64] != best[127:64]) begin
        res = '{done: 1'b1, lt: cand[127:64] < best[127:64]};
      end
    end else if (cand[lb+96 +: 64] != best[lb+96 +: 64]) begin
      res = '{done: 1'b1, lt: cand[lb+96 +: 64] < best[lb+96 +: 64]};
    end else if (cand[lb+64 +: 32] != best[lb+64 +: 32]) begin
      // Different systems: move on to the next level, or at the last level let the uid decide.
      res = '{done: last_lvl, lt: id_lt};
    end else if (cand[lb+32 +: 32] != best[lb+32 +: 32]) begin
      res = '{done: 1'b1, lt: cand[lb+32 +: 32] < best[lb+32 +: 32]};
    end else if (cand[cb +: 32] != best[cb +: 32]) begin
      res = '{done: 1'b1, lt: cand[cb +: 32] < best[cb +: 32]};
    end else begin
      // Full tie at this level: the uid decides.
      res = '{done: 1'b1, lt: id_lt};
    end
    if (step == SW'(0) && cand[127:64] == best[127:64]) begin
      res = '{done: 1'b0, lt: 1'b0};
    end
  end

endmodule

[hdl/lineage_ordered_event_queue_unit.sv]
// Lineage-ordered event queue: slot store, scan sequencer and result port.
//
// Sequencing: staging passes S_RESP on its way to the result transfer; uid
// searches visit S_READ and S_CHECK per valid slot (S_READ per empty slot),
// and peek or remove-next takes each later valid slot through S_CMP in the one
// shared ordering comparator, then LINEAGE_DEPTH result transfers follow.
// Throughput: one command at a time. Reset clears the valid bits, the fill
// count and the staged lineage; slot memory needs no clearing pass.
module lineage_ordered_event_queue_unit #(
  parameter int CAPACITY      = 64,
  parameter int LINEAGE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [63:0] event_time,
  input  logic [31:0] event_id,
  input  logic [31:0] parent_origin,
  input  logic [1:0]  level,
  input  logic [63:0] anc_time,
  input  logic [31:0] anc_system,
  input  logic [31:0] anc_sequence,
  input  logic [31:0] anc_origin,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        present,
  output logic        queue_empty,
  output logic [63:0] out_time,
  output logic [31:0] out_id,
  output logic [31:0] out_origin,
  output logic [1:0]  out_level,
  output logic [63:0] out_anc_time,
  output logic [31:0] out_anc_system,
  output logic [31:0] out_anc_sequence,
  output logic [31:0] out_anc_origin,
  output logic        last
);

  // Each slot is one wide memory word holding the event and its lineage.
  localparam int W  = loeq_pkg::REC_W + LINEAGE_DEPTH * loeq_pkg::LVL_W;
  localparam int PW = $clog2(W);
  localparam int AW = $clog2(CAPACITY);
  localparam int IW = $clog2(CAPACITY + 1);
  localparam int SW = $clog2(LINEAGE_DEPTH + 1);
  localparam int LW = (LINEAGE_DEPTH > 1) ? $clog2(LINEAGE_DEPTH) : 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_READ   = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_CMP    = 7'b0001000,
    S_FINISH = 7'b0010000,
    S_RESP   = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state;

  // Command captured at the input transfer.
  logic [2:0]  cmd;
  logic [63:0] ev_time;
  logic [31:0] ev_id;
  logic [31:0] ev_origin;

  // Staged lineage, one record per level.
  logic [63:0] staged_time     [LINEAGE_DEPTH];
  logic [31:0] staged_system   [LINEAGE_DEPTH];
  logic [31:0] staged_sequence [LINEAGE_DEPTH];
  logic [31:0] staged_origin   [LINEAGE_DEPTH];

  logic [CAPACITY-1:0] slot_valid;
  logic [IW-1:0]       count;

  // Scan state.
  logic [IW-1:0] idx;
  logic [AW-1:0] free_idx;
  logic [AW-1:0] best_idx;
  logic          free_found;
  logic          found;
  logic          have_best;
  logic [SW-1:0] step;
  logic [W-1:0]  best_word;
  logic [LW-1:0] lvl;
  logic [2:0]    resp_status;
  logic          resp_present;

  logic [W-1:0]  rd_word;
  logic [W-1:0]  wr_word;
  logic          ram_we;
  logic          ram_re;
  logic          out_free;
  logic          is_least;
  logic [PW-1:0] off;

  loeq_pkg::cmp_res_t cmp_res;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign is_least = (cmd == loeq_pkg::CMD_POP) || (cmd == loeq_pkg::CMD_PEEK);
  assign ram_re   = (state == S_READ) && (idx != IW'(CAPACITY)) && slot_valid[idx[AW-1:0]];
  assign ram_we   = (state == S_FINISH) && (cmd == loeq_pkg::CMD_INSERT) && !found &&
                    free_found;

  // Word written by an insert: the event and the whole staged lineage.
  always_comb begin
    wr_word = '0;
    wr_word[127:0] = {ev_time, ev_id, ev_origin};
    for (int i = 0; i < LINEAGE_DEPTH; i++) begin
      wr_word[loeq_pkg::REC_W + i*loeq_pkg::LVL_W +: loeq_pkg::LVL_W] =
        {staged_time[i], staged_system[i], staged_sequence[i], staged_origin[i]};
    end
  end

  loeq_ram #(
    .WIDTH (W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (wr_word),
    .re    (ram_re),
    .raddr (idx[AW-1:0]),
    .rdata (rd_word)
  );

  // The single comparator walks the timestamp and then one level per cycle.
  loeq_cmp #(
    .LINEAGE_DEPTH (LINEAGE_DEPTH)
  ) u_cmp (
    .cand (rd_word),
    .best (best_word),
    .step (step),
    .res  (cmp_res)
  );

  assign off = PW'(loeq_pkg::REC_W) + PW'(lvl) * PW'(loeq_pkg::LVL_W);

  // Staged lineage and the valid bits are state that reset must clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINEAGE_DEPTH; i++) begin
        staged_time[i]     <= '0;
        staged_system[i]   <= '0;
        staged_sequence[i] <= '0;
        staged_origin[i]   <= '0;
      end
    end else if (state == S_IDLE && in_valid && command == loeq_pkg::CMD_STAGE &&
                 int'(level) < LINEAGE_DEPTH) begin
      staged_time[LW'(level)]     <= anc_time;
      staged_system[LW'(level)]   <= anc_system;
      staged_sequence[LW'(level)] <= anc_sequence;
      staged_origin[LW'(level)]   <= anc_origin;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      // A waiting result leaves unless a new one replaces it this cycle.
      if (out_valid && !out_stall && state != S_RESP && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd        <= command;
            ev_time    <= event_time;
            ev_id      <= event_id;
            ev_origin  <= parent_origin;
            idx        <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            have_best  <= 1'b0;
            resp_status  <= loeq_pkg::ST_OK;
            resp_present <= 1'b0;
            if (command == loeq_pkg::CMD_STAGE) begin
              state <= S_RESP;
            end else if (command <= loeq_pkg::CMD_CONTAINS) begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (idx == IW'(CAPACITY)) begin
            state <= S_FINISH;
          end else if (slot_valid[idx[AW-1:0]]) begin
            state <= S_CHECK;
          end else begin
            if (!free_found) begin
              free_found <= 1'b1;
              free_idx   <= idx[AW-1:0];
            end
            idx <= idx + IW'(1);
          end
        end
        S_CHECK: begin
          if (is_least) begin
            if (!have_best) begin
              have_best <= 1'b1;
              best_word <= rd_word;
              best_idx  <= idx[AW-1:0];
              idx       <= idx + IW'(1);
              state     <= S_READ;
            end else begin
              step  <= '0;
              state <= S_CMP;
            end
          end else if (rd_word[63:32] == ev_id) begin
            found     <= 1'b1;
            best_word <= rd_word;
            best_idx  <= idx[AW-1:0];
            state     <= S_FINISH;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_READ;
          end
        end
        S_CMP: begin
          if (cmp_res.done) begin
            if (cmp_res.lt) begin
              best_word <= rd_word;
              best_idx  <= idx[AW-1:0];
            end
            idx   <= idx + IW'(1);
            state <= S_READ;
          end else begin
            step <= step + SW'(1);
          end
        end
        S_FINISH: begin
          lvl   <= '0;
          state <= S_RESP;
          case (cmd)
            loeq_pkg::CMD_INSERT: begin
              if (found) begin
                resp_status <= loeq_pkg::ST_DUPLICATE;
              end else if (!free_found) begin
                resp_status <= loeq_pkg::ST_FULL;
              end else begin
                slot_valid[free_idx] <= 1'b1;
                count <= count + IW'(1);
              end
            end
            loeq_pkg::CMD_POP, loeq_pkg::CMD_PEEK: begin
              if (!have_best) begin
                resp_status <= loeq_pkg::ST_EMPTY;
              end else begin
                state <= S_EMIT;
                if (cmd == loeq_pkg::CMD_POP) begin
                  slot_valid[best_idx] <= 1'b0;
                  count <= count - IW'(1);
                end
              end
            end
            loeq_pkg::CMD_REMOVE: begin
              if (!found) begin
                resp_status <= loeq_pkg::ST_NOT_FOUND;
              end else begin
                state <= S_EMIT;
                slot_valid[best_idx] <= 1'b0;
                count <= count - IW'(1);
              end
            end
            default: begin
              resp_present <= found;
            end
          endcase
        end
        S_RESP: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            status           <= resp_status;
            present          <= resp_present;
            queue_empty      <= (count == '0);
            out_time         <= '0;
            out_id           <= '0;
            out_origin       <= '0;
            out_level        <= '0;
            out_anc_time     <= '0;
            out_anc_system   <= '0;
            out_anc_sequence <= '0;
            out_anc_origin   <= '0;
            last             <= 1'b1;
            state            <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            status           <= loeq_pkg::ST_OK;
            present          <= 1'b1;
            queue_empty      <= (count == '0);
            out_time         <= best_word[127:64];
            out_id           <= best_word[63:32];
            out_origin       <= best_word[31:0];
            out_level        <= 2'(lvl);
            out_anc_time     <= best_word[off+96 +: 64];
            out_anc_system   <= best_word[off+64 +: 32];
            out_anc_sequence <= best_word[off+32 +: 32];
            out_anc_origin   <= best_word[off +: 32];
            last             <= (lvl == LW'(LINEAGE_DEPTH - 1));
            if (lvl == LW'(LINEAGE_DEPTH - 1)) begin
              state <= S_IDLE;
            end else begin
              lvl <= lvl + LW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
